### src/ctxsp_pkg.sv
// Shared types, codes and constants of the context slot pool.
`default_nettype none
package ctxsp_pkg;

   // Table size and field widths.
   localparam int TOTAL_SLOTS_DEF = 64;
   localparam int CFG_W = 7;
   localparam int REGION_SUM_W = 9;
   localparam int SERIAL_W = 32;
   localparam int SLOT_W = 6;
   localparam int STATE_W = 2;
   localparam int ENTRY_W = STATE_W + SERIAL_W;

   localparam logic [CFG_W-1:0] DEF_REGION_SIZE = 7'd16;

   // Serials above this limit are near wrap; then all serials are shifted before comparing.
   localparam logic [SERIAL_W-1:0] NEAR_WRAP_LIMIT = 32'hFFFF_F7FF;
   localparam logic [SERIAL_W-1:0] WRAP_OFFSET = 32'd4096;

   // Slot states held in the table.
   localparam logic [STATE_W-1:0] SLOT_FREE = 2'd0;
   localparam logic [STATE_W-1:0] SLOT_ALLOC = 2'd1;
   localparam logic [STATE_W-1:0] SLOT_DATA = 2'd2;

   // Response status codes.
   localparam logic [1:0] STAT_OK = 2'd0;
   localparam logic [1:0] STAT_NONE = 2'd1;
   localparam logic [1:0] STAT_INVALID = 2'd2;

   // Region classes, which are also the configuration register indexes.
   localparam logic [1:0] CLS_SEND = 2'd0;
   localparam logic [1:0] CLS_RECV = 2'd1;
   localparam logic [1:0] CLS_WRITE = 2'd2;
   localparam logic [1:0] CLS_ACK = 2'd3;

   typedef enum logic [1:0] {
      ACT_ALLOC   = 2'd0,
      ACT_DELIVER = 2'd1,
      ACT_RELEASE = 2'd2,
      ACT_FIND    = 2'd3
   } action_type;

   typedef struct packed {
      action_type            action;
      logic [1:0]            op_class;
      logic [SLOT_W-1:0]     slot_index;
      logic [SERIAL_W-1:0]   message_serial;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [SLOT_W-1:0]     found_slot;
      logic [SERIAL_W-1:0]   found_serial;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      CTL_CLEAR,
      CTL_IDLE,
      CTL_DISPATCH,
      CTL_ALLOC,
      CTL_FMAX,
      CTL_FMIN,
      CTL_HOLD
   } ctl_state_type;

   typedef enum logic [2:0] {
      RES_HOLD,
      RES_INVALID,
      RES_NONE,
      RES_WRITE,
      RES_ALLOC,
      RES_FIND
   } res_sel_type;

   typedef struct packed {
      logic        capture;
      logic        clear_en;
      logic        scan_start;
      logic        scan_run;
      logic        acc_clear;
      logic        acc_max;
      logic        acc_min;
      res_sel_type res_sel;
      logic        out_load;
   } ctl_cmd_type;

   typedef struct packed {
      action_type action;
      logic       range_bad;
      logic       region_empty;
      logic       idx_bad;
      logic       hit_free;
      logic       last_data;
      logic       clear_done;
   } dp_stat_type;

endpackage
`default_nettype wire

### src/ctxsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ctxsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                     wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

### src/ctxsp_ctrl.sv
// Controller state machine that sequences clearing, dispatch, scans and the response.
`default_nettype none
module ctxsp_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire ctxsp_pkg::dp_stat_type stat,
   output ctxsp_pkg::ctl_cmd_type     cmd
);

   ctxsp_pkg::ctl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ctxsp_pkg::CTL_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      cmd = '0;
      cmd.res_sel = ctxsp_pkg::RES_HOLD;
      unique case (state_ff)
         ctxsp_pkg::CTL_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.clear_done) begin
               state_in = ctxsp_pkg::CTL_IDLE;
            end
         end
         ctxsp_pkg::CTL_IDLE: begin
            req_ready = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ctxsp_pkg::CTL_DISPATCH;
            end
         end
         ctxsp_pkg::CTL_DISPATCH: begin
            state_in = ctxsp_pkg::CTL_HOLD;
            unique case (stat.action)
               ctxsp_pkg::ACT_ALLOC, ctxsp_pkg::ACT_FIND: begin
                  priority if (stat.range_bad) begin
                     cmd.res_sel = ctxsp_pkg::RES_INVALID;
                  end else if (stat.region_empty) begin
                     cmd.res_sel = ctxsp_pkg::RES_NONE;
                  end else begin
                     cmd.scan_start = 1'b1;
                     cmd.acc_clear = 1'b1;
                     state_in = (stat.action == ctxsp_pkg::ACT_ALLOC) ?
                                ctxsp_pkg::CTL_ALLOC : ctxsp_pkg::CTL_FMAX;
                  end
               end
               ctxsp_pkg::ACT_DELIVER, ctxsp_pkg::ACT_RELEASE: begin
                  cmd.res_sel = stat.idx_bad ? ctxsp_pkg::RES_INVALID : ctxsp_pkg::RES_WRITE;
               end
               default: begin
                  cmd.res_sel = ctxsp_pkg::RES_INVALID;
               end
            endcase
         end
         ctxsp_pkg::CTL_ALLOC: begin
            cmd.scan_run = 1'b1;
            priority if (stat.hit_free) begin
               cmd.res_sel = ctxsp_pkg::RES_ALLOC;
               state_in = ctxsp_pkg::CTL_HOLD;
            end else if (stat.last_data) begin
               cmd.res_sel = ctxsp_pkg::RES_NONE;
               state_in = ctxsp_pkg::CTL_HOLD;
            end
         end
         ctxsp_pkg::CTL_FMAX: begin
            cmd.acc_max = 1'b1;
            if (stat.last_data) begin
               cmd.scan_start = 1'b1;
               state_in = ctxsp_pkg::CTL_FMIN;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         ctxsp_pkg::CTL_FMIN: begin
            cmd.scan_run = 1'b1;
            cmd.acc_min = 1'b1;
            if (stat.last_data) begin
               cmd.res_sel = ctxsp_pkg::RES_FIND;
               state_in = ctxsp_pkg::CTL_HOLD;
            end
         end
         ctxsp_pkg::CTL_HOLD: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in = ctxsp_pkg::CTL_IDLE;
            end
         end
         default: begin
            state_in = ctxsp_pkg::CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

### src/ctxsp_dpath.sv
// Datapath: region registers, slot table, scan pointer, accumulators and response register.
`default_nettype none
module ctxsp_dpath #(
   parameter int TOTAL_SLOTS = ctxsp_pkg::TOTAL_SLOTS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic [1:0]                 csr_index,
   input  wire logic [ctxsp_pkg::CFG_W-1:0] csr_wdata,
   input  wire ctxsp_pkg::req_payload_type req_payload,
   output ctxsp_pkg::rsp_payload_type      rsp_payload,
   input  wire ctxsp_pkg::ctl_cmd_type     cmd,
   output ctxsp_pkg::dp_stat_type          stat
);

   localparam int AW = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
   localparam int SW = $clog2(TOTAL_SLOTS + 1);
   localparam int EW = (SW > ctxsp_pkg::REGION_SUM_W) ? SW : ctxsp_pkg::REGION_SUM_W;

   logic [ctxsp_pkg::CFG_W-1:0] size_ff [4];
   ctxsp_pkg::req_payload_type req_ff;

   logic [1:0]  cls;
   logic [EW-1:0] base, rend, idx_ext;

   logic [EW-1:0] ptr_ff, ptr_in, dptr_ff, dptr_in;
   logic dv_ff, dv_in, issue;
   logic [AW-1:0] clr_ff;

   logic ram_we;
   logic [AW-1:0] ram_waddr;
   logic [ctxsp_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
   logic [ctxsp_pkg::STATE_W-1:0] rd_state;
   logic [ctxsp_pkg::SERIAL_W-1:0] rd_serial;
   logic rd_data;

   logic [ctxsp_pkg::SERIAL_W-1:0] top_ff, top_in, best_ff, best_in, off;
   logic have_ff, have_in, take;
   logic [ctxsp_pkg::SLOT_W-1:0] bslot_ff, bslot_in;

   logic [1:0] res_status_ff, res_status_in;
   logic [ctxsp_pkg::SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic [ctxsp_pkg::SERIAL_W-1:0] res_serial_ff, res_serial_in;
   ctxsp_pkg::rsp_payload_type out_ff;

   // Region bounds for the class in use: find always works on the receive region.
   assign cls = (req_ff.action == ctxsp_pkg::ACT_FIND) ? ctxsp_pkg::CLS_RECV : req_ff.op_class;
   assign base = ((cls != ctxsp_pkg::CLS_SEND) ? EW'(size_ff[0]) : '0)
               + (((cls == ctxsp_pkg::CLS_WRITE) || (cls == ctxsp_pkg::CLS_ACK)) ?
                  EW'(size_ff[1]) : '0)
               + ((cls == ctxsp_pkg::CLS_ACK) ? EW'(size_ff[2]) : '0);
   assign rend = base + EW'(size_ff[cls]);
   assign idx_ext = EW'(req_ff.slot_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff[0] <= ctxsp_pkg::DEF_REGION_SIZE;
         size_ff[1] <= ctxsp_pkg::DEF_REGION_SIZE;
         size_ff[2] <= ctxsp_pkg::DEF_REGION_SIZE;
         size_ff[3] <= ctxsp_pkg::DEF_REGION_SIZE;
      end else if (csr_we) begin
         size_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
   end

   // Scan pointer: a read is issued at ptr, its data arrives in the next cycle tagged by dptr.
   assign issue = cmd.scan_run && (ptr_ff < rend);

   always_comb begin
      ptr_in = ptr_ff;
      dptr_in = dptr_ff;
      dv_in = 1'b0;
      if (cmd.scan_start) begin
         ptr_in = base;
      end else if (issue) begin
         ptr_in = ptr_ff + EW'(1);
         dptr_in = ptr_ff;
         dv_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= 1'b0;
         clr_ff <= '0;
      end else begin
         dv_ff <= dv_in;
         if (cmd.clear_en) begin
            clr_ff <= clr_ff + AW'(1);
         end
      end
      ptr_ff <= ptr_in;
      dptr_ff <= dptr_in;
   end

   // Slot table write port.
   always_comb begin
      ram_we = 1'b0;
      ram_waddr = clr_ff;
      ram_wdata = '0;
      priority if (cmd.clear_en) begin
         ram_we = 1'b1;
         ram_wdata = {ctxsp_pkg::SLOT_FREE, {ctxsp_pkg::SERIAL_W{1'b0}}};
      end else if (cmd.res_sel == ctxsp_pkg::RES_WRITE) begin
         ram_we = 1'b1;
         ram_waddr = idx_ext[AW-1:0];
         ram_wdata = {(req_ff.action == ctxsp_pkg::ACT_DELIVER) ?
                      ctxsp_pkg::SLOT_DATA : ctxsp_pkg::SLOT_FREE, req_ff.message_serial};
      end else if (cmd.res_sel == ctxsp_pkg::RES_ALLOC) begin
         ram_we = 1'b1;
         ram_waddr = dptr_ff[AW-1:0];
         ram_wdata = {ctxsp_pkg::SLOT_ALLOC, {ctxsp_pkg::SERIAL_W{1'b0}}};
      end else begin
         ram_we = 1'b0;
      end
   end

   ctxsp_ram #(
      .WIDTH(ctxsp_pkg::ENTRY_W),
      .DEPTH(TOTAL_SLOTS)
   ) u_table (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ptr_ff[AW-1:0]),
      .rdata(ram_rdata)
   );

   assign rd_state = ram_rdata[ctxsp_pkg::ENTRY_W-1:ctxsp_pkg::SERIAL_W];
   assign rd_serial = ram_rdata[ctxsp_pkg::SERIAL_W-1:0];
   assign rd_data = dv_ff && (rd_state == ctxsp_pkg::SLOT_DATA);

   // Two-pass oldest search: first the largest serial, then the smallest after the offset.
   assign off = (top_ff > ctxsp_pkg::NEAR_WRAP_LIMIT) ? ctxsp_pkg::WRAP_OFFSET : '0;
   assign take = cmd.acc_min && rd_data &&
                 (!have_ff || ((rd_serial - off) < (best_ff - off)));

   always_comb begin
      top_in = top_ff;
      have_in = have_ff;
      best_in = best_ff;
      bslot_in = bslot_ff;
      if (cmd.acc_clear) begin
         top_in = '0;
         have_in = 1'b0;
      end else begin
         if (cmd.acc_max && rd_data && (rd_serial > top_ff)) begin
            top_in = rd_serial;
         end
         if (take) begin
            have_in = 1'b1;
            best_in = rd_serial;
            bslot_in = dptr_ff[ctxsp_pkg::SLOT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
      top_ff <= top_in;
      best_ff <= best_in;
      bslot_ff <= bslot_in;
   end

   always_comb begin
      res_status_in = res_status_ff;
      res_slot_in = res_slot_ff;
      res_serial_in = res_serial_ff;
      unique case (cmd.res_sel)
         ctxsp_pkg::RES_HOLD: begin
         end
         ctxsp_pkg::RES_INVALID: begin
            res_status_in = ctxsp_pkg::STAT_INVALID;
            res_slot_in = '0;
            res_serial_in = '0;
         end
         ctxsp_pkg::RES_NONE: begin
            res_status_in = ctxsp_pkg::STAT_NONE;
            res_slot_in = '0;
            res_serial_in = '0;
         end
         ctxsp_pkg::RES_WRITE: begin
            res_status_in = ctxsp_pkg::STAT_OK;
            res_slot_in = req_ff.slot_index;
            res_serial_in = '0;
         end
         ctxsp_pkg::RES_ALLOC: begin
            res_status_in = ctxsp_pkg::STAT_OK;
            res_slot_in = dptr_ff[ctxsp_pkg::SLOT_W-1:0];
            res_serial_in = '0;
         end
         ctxsp_pkg::RES_FIND: begin
            res_status_in = have_in ? ctxsp_pkg::STAT_OK : ctxsp_pkg::STAT_NONE;
            res_slot_in = have_in ? bslot_in : '0;
            res_serial_in = have_in ? best_in : '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_slot_ff <= res_slot_in;
      res_serial_ff <= res_serial_in;
      if (cmd.out_load) begin
         out_ff.status <= res_status_ff;
         out_ff.found_slot <= res_slot_ff;
         out_ff.found_serial <= res_serial_ff;
      end
   end

   assign rsp_payload = out_ff;

   assign stat.action = req_ff.action;
   assign stat.range_bad = rend > EW'(TOTAL_SLOTS);
   assign stat.region_empty = (size_ff[cls] == '0);
   assign stat.idx_bad = idx_ext >= EW'(TOTAL_SLOTS);
   assign stat.hit_free = dv_ff && (rd_state == ctxsp_pkg::SLOT_FREE);
   assign stat.last_data = dv_ff && ((dptr_ff + EW'(1)) == rend);
   assign stat.clear_done = (clr_ff == AW'(TOTAL_SLOTS - 1));

endmodule
`default_nettype wire

### src/context_slot_pool_unit.sv
// Top level of the context slot pool: controller, datapath and checks.
// Deliver, release and rejected requests answer without a scan of the slot table.
// Allocate scans its region of n slots once and find-oldest scans its region twice, in passes
// that read the slot table one entry per cycle through its read port.
// One request is in work at a time; the next beat is taken once the response is registered.
// Reset: sizes return to 16 and a clearing pass frees every slot.
`default_nettype none
module context_slot_pool_unit #(
   parameter int TOTAL_SLOTS = ctxsp_pkg::TOTAL_SLOTS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire ctxsp_pkg::req_payload_type req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output ctxsp_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                       csr_we,
   input  wire logic [1:0]                 csr_index,
   input  wire logic [ctxsp_pkg::CFG_W-1:0] csr_wdata
);

   // The controller issues commands each cycle; the datapath answers with status flags.
   ctxsp_pkg::ctl_cmd_type cmd;
   ctxsp_pkg::dp_stat_type stat;

   // The controller owns the handshakes and the sequence of each request.
   ctxsp_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .stat(stat),
      .cmd(cmd)
   );

   // The datapath holds the region sizes, the slot table and the response register.
   ctxsp_dpath #(
      .TOTAL_SLOTS(TOTAL_SLOTS)
   ) u_dpath (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_payload(req_payload),
      .rsp_payload(rsp_payload),
      .cmd(cmd),
      .stat(stat)
   );

   // A finished response is only moved to the output when the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("response loaded over an untaken beat");

   // Only one request is in work: the cycle after a request beat, no other is taken.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while one is in work");

   // A failed request carries no slot and no serial.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status != ctxsp_pkg::STAT_OK)) |->
      ((rsp_payload.found_slot == '0) && (rsp_payload.found_serial == '0)))
      else $error("failed response with nonzero slot or serial");

   // A scan is never restarted and advanced in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.scan_start && cmd.scan_run))
      else $error("scan pointer restarted while advancing");

endmodule
`default_nettype wire

### tb/tb_context_slot_pool_unit.sv
// Self-checking testbench for the context slot pool: directed table, then random phases.
`timescale 1ns / 100ps
module tb_context_slot_pool_unit;
   import ctxsp_pkg::*;

   // The block is built with its default table size; the testbench mirrors it.
   localparam int TABLE_SLOTS = TOTAL_SLOTS_DEF;
   // Slowest answer is a find over the whole table: two passes plus overhead.
   localparam int SETTLE_CYCLES = 2 * TABLE_SLOTS + 20;
   // Number of answers after which the receiver holds off for a long stretch.
   localparam int HOLD_AFTER_BEATS = 120;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_PHASES = 9;
   localparam int ITEMS_PER_PHASE = 60;

   // One row of the directed stimulus: either a register write or a request beat.
   // Rows marked typed carry an answer written out by hand; all others are predicted.
   typedef struct packed {
      bit              cfg_row;
      logic [1:0]      cfg_reg;
      logic [CFG_W-1:0] cfg_val;
      req_payload_type req;
      bit              typed;
      rsp_payload_type want;
   } plan_row_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;
   logic            csr_we;
   logic [1:0]      csr_index;
   logic [CFG_W-1:0] csr_wdata;

   // Shadow copy of the pool: slot states, stored serials and the region sizes.
   logic [STATE_W-1:0]  pool_state [TABLE_SLOTS];
   logic [SERIAL_W-1:0] pool_serial [TABLE_SLOTS];
   logic [CFG_W-1:0]    region_len [4];

   rsp_payload_type pending_answers [$];
   plan_row_type    directed_plan [$];
   rsp_payload_type oldest_answer;
   int unsigned     answer_beats;
   int unsigned     mismatch_count;
   int unsigned     burst_left;
   logic [SERIAL_W-1:0] last_serial;

   context_slot_pool_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // 12 ns clock, high first.
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Prints one line per mismatch and keeps the count that decides the verdict.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Computes the answer the pool gives to one request and updates the shadow state.
   // Allocate scans its region from the bottom. Find looks at the receive region only;
   // when the largest stored serial sits near wrap, every serial is shifted down by the
   // wrap offset first, so that serials that have already wrapped sort as the newest.
   function automatic rsp_payload_type pool_answer(input req_payload_type r);
      rsp_payload_type     a;
      int                  base;
      int                  last;
      int                  i;
      bit                  have;
      logic [SERIAL_W-1:0] top;
      logic [SERIAL_W-1:0] off;
      logic [SERIAL_W-1:0] best;
      a = '0;
      have = 1'b0;
      case (r.action)
         ACT_ALLOC: begin
            base = 0;
            for (i = 0; i < int'(r.op_class); i++) begin
               base += int'(region_len[i]);
            end
            last = base + int'(region_len[r.op_class]);
            if (last > TABLE_SLOTS) begin
               a.status = STAT_INVALID;
            end else begin
               a.status = STAT_NONE;
               for (i = base; i < last; i++) begin
                  if (!have && pool_state[i] == SLOT_FREE) begin
                     pool_state[i] = SLOT_ALLOC;
                     a.status = STAT_OK;
                     a.found_slot = SLOT_W'(i);
                     have = 1'b1;
                  end
               end
            end
         end
         // A six-bit index can never pass the end of a 64-slot table, so deliver and
         // release are always taken, whatever state the slot is in.
         ACT_DELIVER: begin
            pool_state[r.slot_index] = SLOT_DATA;
            pool_serial[r.slot_index] = r.message_serial;
            a.status = STAT_OK;
            a.found_slot = r.slot_index;
         end
         ACT_RELEASE: begin
            // The stored serial is left in place on release.
            pool_state[r.slot_index] = SLOT_FREE;
            a.status = STAT_OK;
            a.found_slot = r.slot_index;
         end
         default: begin
            base = int'(region_len[CLS_SEND]);
            last = base + int'(region_len[CLS_RECV]);
            if (last > TABLE_SLOTS) begin
               a.status = STAT_INVALID;
            end else begin
               top = '0;
               for (i = base; i < last; i++) begin
                  if (pool_state[i] == SLOT_DATA && pool_serial[i] > top) begin
                     top = pool_serial[i];
                  end
               end
               off = (top > NEAR_WRAP_LIMIT) ? WRAP_OFFSET : '0;
               best = '1;
               // Strict less-than keeps the lowest slot among equal serials.
               for (i = base; i < last; i++) begin
                  if (pool_state[i] == SLOT_DATA &&
                      (!have || (pool_serial[i] - off) < (best - off))) begin
                     best = pool_serial[i];
                     a.found_slot = SLOT_W'(i);
                     have = 1'b1;
                  end
               end
               if (have) begin
                  a.status = STAT_OK;
                  a.found_serial = best;
               end else begin
                  a.status = STAT_NONE;
                  a.found_slot = '0;
               end
            end
         end
      endcase
      return a;
   endfunction

   function automatic void plan_req(input action_type act, input logic [1:0] cls,
                                    input logic [SLOT_W-1:0] idx,
                                    input logic [SERIAL_W-1:0] ser, input bit typed = 1'b0,
                                    input logic [1:0] st = STAT_OK,
                                    input logic [SLOT_W-1:0] slot = '0);
      plan_row_type row;
      row = '0;
      row.req.action = act;
      row.req.op_class = cls;
      row.req.slot_index = idx;
      row.req.message_serial = ser;
      row.typed = typed;
      row.want.status = st;
      row.want.found_slot = slot;
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_cfg(input logic [1:0] reg_idx, input logic [CFG_W-1:0] val);
      plan_row_type row;
      row = '0;
      row.cfg_row = 1'b1;
      row.cfg_reg = reg_idx;
      row.cfg_val = val;
      directed_plan.push_back(row);
   endfunction

   // Offers one request beat and holds it until it is taken. The sender works in bursts:
   // when a burst is used up it idles for a random gap, sometimes none at all.
   // Called and left at a falling edge.
   task automatic send_req(input req_payload_type p, input bit typed,
                           input rsp_payload_type want);
      int unsigned     gap;
      rsp_payload_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_valid = 1'b1;
      req_payload = p;
      do begin
         @(posedge clock);
      end while (!req_ready);
      // The shadow state moves on every beat, even where the answer is typed in.
      predicted = pool_answer(p);
      pending_answers.push_back(typed ? want : predicted);
      burst_left--;
      @(negedge clock);
   endtask

   // Stops offering requests and waits until every expected answer has come back,
   // so that the block is idle before a register write.
   task automatic drain_answers();
      req_valid = 1'b0;
      burst_left = 0;
      while (pending_answers.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // One register write, one cycle long. Called and left at a falling edge.
   task automatic write_csr(input logic [1:0] reg_idx, input logic [CFG_W-1:0] val);
      csr_we = 1'b1;
      csr_index = reg_idx;
      csr_wdata = val;
      region_len[reg_idx] = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Builds a random request. Deliveries lean toward the receive region so that finds
   // have data to sort, and serials are drawn from several pools: the full range, just
   // around the near-wrap limit, small values that look already wrapped, and repeats.
   function automatic req_payload_type make_random_req();
      req_payload_type r;
      int unsigned     pick;
      int              lo;
      int              hi;
      r.op_class = 2'($urandom_range(0, 3));
      r.slot_index = SLOT_W'($urandom_range(0, TABLE_SLOTS - 1));
      r.message_serial = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         r.action = ACT_ALLOC;
      end else if (pick < 60) begin
         r.action = ACT_DELIVER;
      end else if (pick < 80) begin
         r.action = ACT_RELEASE;
      end else begin
         r.action = ACT_FIND;
      end
      lo = int'(region_len[CLS_SEND]);
      hi = lo + int'(region_len[CLS_RECV]);
      if (hi > TABLE_SLOTS) begin
         hi = TABLE_SLOTS;
      end
      if (r.action != ACT_ALLOC && r.action != ACT_FIND && hi > lo &&
          $urandom_range(0, 9) < 6) begin
         r.slot_index = SLOT_W'($urandom_range(lo, hi - 1));
      end
      case ($urandom_range(0, 3))
         0: r.message_serial = $urandom;
         1: r.message_serial = 32'hFFFF_F000 + $urandom_range(0, 4095);
         2: r.message_serial = $urandom_range(0, 300);
         default: r.message_serial = last_serial;
      endcase
      if (r.action == ACT_DELIVER) begin
         last_serial = r.message_serial;
      end
      return r;
   endfunction

   // Answer checker: every accepted answer is compared with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         answer_beats++;
         if (pending_answers.size() == 0) begin
            report_mismatch("answer beat with nothing expected", 32'(rsp_payload.status),
                            32'd0);
         end else begin
            oldest_answer = pending_answers.pop_front();
            if (rsp_payload.status !== oldest_answer.status) begin
               report_mismatch("status", 32'(rsp_payload.status),
                               32'(oldest_answer.status));
            end
            if (rsp_payload.found_slot !== oldest_answer.found_slot) begin
               report_mismatch("found_slot", 32'(rsp_payload.found_slot),
                               32'(oldest_answer.found_slot));
            end
            if (rsp_payload.found_serial !== oldest_answer.found_serial) begin
               report_mismatch("found_serial", rsp_payload.found_serial,
                               oldest_answer.found_serial);
            end
         end
      end
   end

   // Receiver: ready steps through a 16-bit pattern that is redrawn among choices from
   // always ready to long runs of stalls. Once, after enough answers, it holds off for
   // a long stretch while the sender keeps offering, so that the input side backs up.
   initial begin
      int unsigned cyc;
      logic [15:0] pattern;
      bit          held_off;
      cyc = 0;
      pattern = '1;
      held_off = 1'b0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end
      forever begin
         if (!held_off && answer_beats >= HOLD_AFTER_BEATS) begin
            held_off = 1'b1;
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (cyc % 48 == 0) begin
            case ($urandom_range(0, 4))
               0, 1: pattern = '1;
               2: pattern = 16'($urandom);
               3: pattern = 16'hFF00;
               default: pattern = 16'h1111;
            endcase
         end
         rsp_ready = pattern[cyc % 16];
         cyc++;
         @(negedge clock);
      end
   end

   // Main sequence: reset, the directed table, then random phases, each with its own
   // region sizes, and finally the drain and the verdict.
   initial begin
      int               ph;
      int               n;
      int               room;
      int unsigned      mode;
      int unsigned      big_reg;
      logic [CFG_W-1:0] sizes [4];
      plan_row_type     row;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_index = CLS_SEND;
      csr_wdata = '0;
      answer_beats = 0;
      mismatch_count = 0;
      burst_left = 0;
      last_serial = '0;
      for (n = 0; n < 4; n++) begin
         region_len[n] = DEF_REGION_SIZE;
      end
      for (n = 0; n < TABLE_SLOTS; n++) begin
         pool_state[n] = SLOT_FREE;
         pool_serial[n] = '0;
      end

      // Directed table. With reset sizes the regions are send 0-15, receive 16-31,
      // write 32-47 and acknowledge 48-63.
      // Nothing delivered yet, so find has no data.
      plan_req(ACT_FIND, CLS_SEND, 6'd0, 32'd0, 1'b1, STAT_NONE, 6'd0);
      plan_req(ACT_ALLOC, CLS_SEND, 6'd0, 32'd0, 1'b1, STAT_OK, 6'd0);
      plan_req(ACT_ALLOC, CLS_ACK, 6'd0, 32'd0, 1'b1, STAT_OK, 6'd48);
      // Field extremes on deliver; the answer echoes the index.
      plan_req(ACT_DELIVER, CLS_ACK, 6'd63, 32'hFFFF_FFFF, 1'b1, STAT_OK, 6'd63);
      plan_req(ACT_DELIVER, CLS_SEND, 6'd0, 32'd0, 1'b1, STAT_OK, 6'd0);
      // A serial past the near-wrap limit next to small, already wrapped ones.
      plan_req(ACT_DELIVER, CLS_RECV, 6'd16, 32'hFFFF_F800, 1'b1, STAT_OK, 6'd16);
      plan_req(ACT_DELIVER, CLS_RECV, 6'd17, 32'd5);
      plan_req(ACT_DELIVER, CLS_RECV, 6'd18, 32'd5);
      plan_req(ACT_FIND, CLS_RECV, 6'd0, 32'd0);
      plan_req(ACT_RELEASE, CLS_RECV, 6'd16, 32'd0, 1'b1, STAT_OK, 6'd16);
      // Exactly at the limit: no shift, and the equal serials pick the lower slot.
      plan_req(ACT_DELIVER, CLS_RECV, 6'd20, 32'hFFFF_F7FF);
      plan_req(ACT_FIND, CLS_RECV, 6'd0, 32'd0);
      plan_req(ACT_ALLOC, CLS_RECV, 6'd0, 32'd0);
      // Empty receive region.
      plan_cfg(CLS_RECV, 7'd0);
      plan_req(ACT_FIND, CLS_RECV, 6'd0, 32'd0, 1'b1, STAT_NONE, 6'd0);
      plan_req(ACT_ALLOC, CLS_RECV, 6'd0, 32'd0, 1'b1, STAT_NONE, 6'd0);
      // Send takes the whole table: the write region now lies past its end.
      plan_cfg(CLS_SEND, 7'd64);
      plan_req(ACT_ALLOC, CLS_SEND, 6'd0, 32'd0);
      plan_req(ACT_ALLOC, CLS_WRITE, 6'd0, 32'd0, 1'b1, STAT_INVALID, 6'd0);
      plan_cfg(CLS_RECV, 7'd1);
      plan_req(ACT_FIND, CLS_RECV, 6'd0, 32'd0, 1'b1, STAT_INVALID, 6'd0);
      plan_cfg(CLS_SEND, 7'd16);
      plan_cfg(CLS_RECV, 7'd16);
      plan_cfg(CLS_ACK, 7'd64);
      plan_req(ACT_ALLOC, CLS_ACK, 6'd0, 32'd0, 1'b1, STAT_INVALID, 6'd0);
      plan_req(ACT_ALLOC, CLS_WRITE, 6'd0, 32'd0);
      plan_req(ACT_RELEASE, CLS_ACK, 6'd63, 32'd0, 1'b1, STAT_OK, 6'd63);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.cfg_row) begin
            drain_answers();
            write_csr(row.cfg_reg, row.cfg_val);
         end else begin
            send_req(row.req, row.typed, row.want);
         end
      end

      // Random phases. The size mode cycles through small regions, one region owning
      // the whole table, random sizes that may run past the end, and partitions that fit the table.
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         mode = ph % 4;
         room = TABLE_SLOTS;
         big_reg = (ph / 4 + 1) % 4;
         for (n = 0; n < 4; n++) begin
            case (mode)
               0: sizes[n] = CFG_W'($urandom_range(0, 6));
               1: sizes[n] = (n == int'(big_reg)) ? CFG_W'(TABLE_SLOTS) : '0;
               2: sizes[n] = CFG_W'($urandom_range(0, TABLE_SLOTS));
               default: begin
                  sizes[n] = CFG_W'($urandom_range(0, room));
                  room -= int'(sizes[n]);
               end
            endcase
         end
         drain_answers();
         for (n = 0; n < 4; n++) begin
            write_csr(2'(n), sizes[n]);
         end
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_req(make_random_req(), 1'b0, '0);
         end
      end

      drain_answers();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_context_slot_pool_unit: done, clean");
      end else begin
         $display("tb_context_slot_pool_unit: done, errors");
      end
      $finish;
   end

   // Watchdog: a correct run needs on the order of a millisecond of simulated time.
   initial begin
      #(10_000_000);
      $display("tb_context_slot_pool_unit: done, errors");
      $finish;
   end

endmodule
